FILE: src/eepp_pkg.sv
`default_nettype none
package eepp_pkg;

   localparam int MAX_NAME_LEN_DEF = 63;

   localparam int OP_W   = 10;
   localparam int SEQ_W  = 63;
   localparam int NLEN_W = 6;

   localparam logic [OP_W-1:0] OP_LIMIT = 10'd99;

   // literal selectors
   localparam logic [1:0] LIT_OPEN = 2'd0;
   localparam logic [1:0] LIT_SKEY = 2'd1;
   localparam logic [1:0] LIT_OKEY = 2'd2;
   localparam logic [1:0] LIT_NULL = 2'd3;

   typedef struct packed {
      logic              accepted;
      logic [OP_W-1:0]   op_value;
      logic              sequence_present;
      logic [SEQ_W-1:0]  sequence_value;
      logic              name_present;
      logic [NLEN_W-1:0] name_length;
   } eepp_result_type;

   function automatic logic [2:0] lit_len(input logic [1:0] sel);
      logic [2:0] len;
      case (sel)
         LIT_OPEN: len = 3'd5;
         LIT_SKEY: len = 3'd5;
         LIT_OKEY: len = 3'd6;
         LIT_NULL: len = 3'd4;
         default:  len = 3'd4;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (sel)
         LIT_OPEN: begin
            case (pos)
               3'd0:    ch = "{";
               3'd1:    ch = "\"";
               3'd2:    ch = "t";
               3'd3:    ch = "\"";
               3'd4:    ch = ":";
               default: ch = 8'h00;
            endcase
         end
         LIT_SKEY: begin
            case (pos)
               3'd0:    ch = ",";
               3'd1:    ch = "\"";
               3'd2:    ch = "s";
               3'd3:    ch = "\"";
               3'd4:    ch = ":";
               default: ch = 8'h00;
            endcase
         end
         LIT_OKEY: begin
            case (pos)
               3'd0:    ch = ",";
               3'd1:    ch = "\"";
               3'd2:    ch = "o";
               3'd3:    ch = "p";
               3'd4:    ch = "\"";
               3'd5:    ch = ":";
               default: ch = 8'h00;
            endcase
         end
         LIT_NULL: begin
            case (pos)
               3'd0:    ch = "n";
               3'd1:    ch = "u";
               3'd2:    ch = "l";
               3'd3:    ch = "l";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

FILE: src/eepp_req_if.sv
`default_nettype none
interface eepp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;

   modport source (output valid, output payload_byte, output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: src/eepp_rsp_if.sv
`default_nettype none
interface eepp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        accepted;
   logic [eepp_pkg::OP_W-1:0]   op_value;
   logic                        sequence_present;
   logic [eepp_pkg::SEQ_W-1:0]  sequence_value;
   logic                        name_present;
   logic [eepp_pkg::NLEN_W-1:0] name_length;

   modport source (output valid, output accepted, output op_value, output sequence_present,
                   output sequence_value, output name_present, output name_length,
                   input ready);
   modport sink   (input valid, input accepted, input op_value, input sequence_present,
                   input sequence_value, input name_present, input name_length,
                   output ready);
endinterface
`default_nettype wire

FILE: src/eepp_parser.sv
`default_nettype none
module eepp_parser #(
   parameter int MAX_NAME_LEN = eepp_pkg::MAX_NAME_LEN_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_fire,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    in_last,
   output eepp_pkg::eepp_result_type    result
);

   localparam int CNT_W = $clog2(MAX_NAME_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NAME_LEN);

   localparam logic [3:0] PH_PREFIX     = 4'd0;
   localparam logic [3:0] PH_NAME_START = 4'd1;
   localparam logic [3:0] PH_NAME_NULL  = 4'd2;
   localparam logic [3:0] PH_NAME_BODY  = 4'd3;
   localparam logic [3:0] PH_SKEY       = 4'd4;
   localparam logic [3:0] PH_SEQ_START  = 4'd5;
   localparam logic [3:0] PH_SEQ_NULL   = 4'd6;
   localparam logic [3:0] PH_SEQ_DIGITS = 4'd7;
   localparam logic [3:0] PH_OPKEY      = 4'd8;
   localparam logic [3:0] PH_OP_FIRST   = 4'd9;
   localparam logic [3:0] PH_OP_DIGITS  = 4'd10;
   localparam logic [3:0] PH_TAIL       = 4'd11;
   localparam logic [3:0] PH_REJECT     = 4'd12;

   logic [3:0]                 phase_ff, phase_in;
   logic [2:0]                 pos_ff, pos_in;
   logic [eepp_pkg::SEQ_W-1:0] seq_ff, seq_in;
   logic [eepp_pkg::OP_W-1:0]  op_ff, op_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       sflag_ff, sflag_in;
   logic                       nflag_ff, nflag_in;

   logic       is_digit, is_name;
   logic [3:0] digit;
   logic [eepp_pkg::SEQ_W+3:0] seq_next;
   logic [eepp_pkg::OP_W-1:0]  op_next;
   logic       lit_act;
   logic [1:0] lit_sel;
   logic [2:0] lit_pos;
   logic [3:0] lit_next;
   logic [CNT_W+eepp_pkg::NLEN_W-1:0] cnt_ext;

   assign is_digit = (in_byte >= "0") && (in_byte <= "9");
   assign is_name  = ((in_byte >= "A") && (in_byte <= "Z")) || (in_byte == "_") || is_digit;
   assign digit    = in_byte[3:0];

   // acc * 10 + d as shift-add; anything above bit 62 is an overflow
   assign seq_next = ({4'b0, seq_ff} << 3) + ({4'b0, seq_ff} << 1)
                   + {{(eepp_pkg::SEQ_W){1'b0}}, digit};
   assign op_next  = {op_ff[6:0], 3'b0} + {op_ff[8:0], 1'b0} + {6'b0, digit};

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      seq_in   = seq_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      sflag_in = sflag_ff;
      nflag_in = nflag_ff;
      lit_act  = 1'b0;
      lit_sel  = eepp_pkg::LIT_OPEN;
      lit_pos  = pos_ff;
      lit_next = PH_NAME_START;

      case (phase_ff)
         PH_PREFIX: begin
            lit_act = 1'b1;
         end
         PH_NAME_START: begin
            if (in_byte == "n") begin
               pos_in   = 3'd1;
               phase_in = PH_NAME_NULL;
            end else if (in_byte == "\"") begin
               nflag_in = 1'b1;
               cnt_in   = '0;
               phase_in = PH_NAME_BODY;
            end else begin
               phase_in = PH_REJECT;
            end
         end
         PH_NAME_NULL: begin
            lit_act  = 1'b1;
            lit_sel  = eepp_pkg::LIT_NULL;
            lit_next = PH_SKEY;
         end
         PH_NAME_BODY: begin
            if (is_name) begin
               if (cnt_ff >= CNT_MAX) phase_in = PH_REJECT;
               else                   cnt_in   = cnt_ff + 1'b1;
            end else if ((in_byte == "\"") && (cnt_ff != '0)) begin
               phase_in = PH_SKEY;
            end else begin
               phase_in = PH_REJECT;
            end
         end
         PH_SKEY: begin
            lit_act  = 1'b1;
            lit_sel  = eepp_pkg::LIT_SKEY;
            lit_next = PH_SEQ_START;
         end
         PH_SEQ_START: begin
            if (in_byte == "n") begin
               pos_in   = 3'd1;
               phase_in = PH_SEQ_NULL;
            end else if (is_digit) begin
               sflag_in = 1'b1;
               seq_in   = {{(eepp_pkg::SEQ_W-4){1'b0}}, digit};
               phase_in = PH_SEQ_DIGITS;
            end else begin
               phase_in = PH_REJECT;
            end
         end
         PH_SEQ_NULL: begin
            lit_act  = 1'b1;
            lit_sel  = eepp_pkg::LIT_NULL;
            lit_next = PH_OPKEY;
         end
         PH_SEQ_DIGITS: begin
            if (is_digit) begin
               if (|seq_next[eepp_pkg::SEQ_W+3:eepp_pkg::SEQ_W]) phase_in = PH_REJECT;
               else seq_in = seq_next[eepp_pkg::SEQ_W-1:0];
            end else begin
               // this byte already opens the op key
               phase_in = PH_OPKEY;
               lit_act  = 1'b1;
               lit_sel  = eepp_pkg::LIT_OKEY;
               lit_pos  = 3'd0;
               lit_next = PH_OP_FIRST;
            end
         end
         PH_OPKEY: begin
            lit_act  = 1'b1;
            lit_sel  = eepp_pkg::LIT_OKEY;
            lit_next = PH_OP_FIRST;
         end
         PH_OP_FIRST: begin
            if (is_digit) begin
               op_in    = {6'b0, digit};
               phase_in = PH_OP_DIGITS;
            end else begin
               phase_in = PH_REJECT;
            end
         end
         PH_OP_DIGITS: begin
            if (is_digit) begin
               if (op_ff > eepp_pkg::OP_LIMIT) phase_in = PH_REJECT;
               else                            op_in    = op_next;
            end else begin
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
         end
         PH_REJECT: begin
         end
         default: begin
            phase_in = PH_REJECT;
         end
      endcase

      if (lit_act) begin
         if ((lit_pos >= eepp_pkg::lit_len(lit_sel)) ||
             (eepp_pkg::lit_char(lit_sel, lit_pos) != in_byte)) begin
            phase_in = PH_REJECT;
         end else if ((lit_pos + 3'd1) == eepp_pkg::lit_len(lit_sel)) begin
            pos_in   = 3'd0;
            phase_in = lit_next;
         end else begin
            pos_in   = lit_pos + 3'd1;
         end
      end
   end

   assign cnt_ext = {{(eepp_pkg::NLEN_W){1'b0}}, cnt_in};

   always_comb begin
      result = '0;
      if ((phase_in == PH_OP_DIGITS) || (phase_in == PH_TAIL)) begin
         result.accepted         = 1'b1;
         result.op_value         = op_in;
         result.sequence_present = sflag_in;
         result.sequence_value   = sflag_in ? seq_in : '0;
         result.name_present     = nflag_in;
         result.name_length      = nflag_in ? cnt_ext[eepp_pkg::NLEN_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (in_fire && in_last)) begin
         phase_ff <= PH_PREFIX;
         pos_ff   <= '0;
         seq_ff   <= '0;
         op_ff    <= '0;
         cnt_ff   <= '0;
         sflag_ff <= 1'b0;
         nflag_ff <= 1'b0;
      end else if (in_fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         seq_ff   <= seq_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
         sflag_ff <= sflag_in;
         nflag_ff <= nflag_in;
      end
   end

   a_name_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("name counter above limit");

   a_op_bound: assert property (@(posedge clock) disable iff (reset)
      op_ff <= 10'd999)
      else $error("op accumulator above 999");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (in_fire && in_last) |=> (phase_ff == PH_PREFIX) && (pos_ff == 3'd0) && !sflag_ff)
      else $error("parser not back at start after last byte");

   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_REJECT && in_fire && !in_last) |=> (phase_ff == PH_REJECT))
      else $error("rejected payload resumed parsing");

endmodule
`default_nettype wire

FILE: src/eepp_rsp_buffer.sv
`default_nettype none
module eepp_rsp_buffer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire eepp_pkg::eepp_result_type push_data,
   output logic                           full,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output eepp_pkg::eepp_result_type      out_data
);

   logic                      out_valid_ff;
   logic                      skid_valid_ff;
   eepp_pkg::eepp_result_type out_ff;
   eepp_pkg::eepp_result_type skid_ff;
   logic                      out_take;

   assign out_take  = !out_valid_ff || out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (out_valid_ff && !skid_valid_ff && out_ff == $past(skid_ff)))
      else $error("skid entry lost on drain");

endmodule
`default_nettype wire

FILE: src/event_envelope_prefix_parser_core.sv
// The result of a payload is registered onto rsp_chan, via its skid entry while rsp_chan is stalled.
// One byte per cycle while req_chan.ready is high; parser state and result update in a single pass.
// req_chan.ready drops only while both the result register and its skid entry are occupied.
// Reset: synchronous, active high; clears parser state and both result valid flags.
// Payload registers hold whatever they last loaded and need no reset.
`default_nettype none
module event_envelope_prefix_parser_core #(
   parameter int MAX_NAME_LEN = eepp_pkg::MAX_NAME_LEN_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   eepp_req_if.sink   req_chan,
   eepp_rsp_if.source rsp_chan
);

   logic                      req_fire;
   logic                      skid_full;
   eepp_pkg::eepp_result_type parse_result;
   eepp_pkg::eepp_result_type rsp_data;

   // Hold off new bytes only when the skid entry is taken; a waiting result
   // does not stall the byte stream.
   assign req_chan.ready = !skid_full;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Advance the parser on every byte transfer; the result is formed from the
   // post-byte state and is only meaningful on the last byte.
   eepp_parser #(
      .MAX_NAME_LEN (MAX_NAME_LEN)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_fire (req_fire),
      .in_byte (req_chan.payload_byte),
      .in_last (req_chan.last_byte),
      .result  (parse_result)
   );

   // Register the result, with one skid entry so a stalled sink does not
   // block the next payload's bytes.
   eepp_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire && req_chan.last_byte),
      .push_data (parse_result),
      .full      (skid_full),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.accepted         = rsp_data.accepted;
   assign rsp_chan.op_value         = rsp_data.op_value;
   assign rsp_chan.sequence_present = rsp_data.sequence_present;
   assign rsp_chan.sequence_value   = rsp_data.sequence_value;
   assign rsp_chan.name_present     = rsp_data.name_present;
   assign rsp_chan.name_length      = rsp_data.name_length;

endmodule
`default_nettype wire
